### sv/serial_hex_loader_parser_assert.svh
// Assertion macros shared by the serial hex loader parser RTL.
`ifndef SERIAL_HEX_LOADER_PARSER_ASSERT_SVH
`define SERIAL_HEX_LOADER_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SHLP_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SHLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/shlp_pkg.sv
// Types, constants and helpers for the serial hex loader parser.
`timescale 1ns / 1ps

package shlp_pkg;

   localparam int BYTES_PER_LINE = 16;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UP_D  = 8'h44;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_UP_G  = 8'h47;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_ZERO = 9'b000000010,
      ST_X    = 9'b000000100,
      ST_ADDR = 9'b000001000,
      ST_DHI  = 9'b000010000,
      ST_DLO  = 9'b000100000,
      ST_LEN  = 9'b001000000,
      ST_SKIP = 9'b010000000,
      ST_HALT = 9'b100000000
   } phase_type;

   typedef enum logic [1:0] {
      TGT_LOAD = 2'd0,
      TGT_DUMP = 2'd1,
      TGT_GO   = 2'd2
   } target_type;

   typedef struct packed {
      phase_type   phase;
      target_type  target;
      logic [31:0] address_acc;
      logic [31:0] count_acc;
      logic [3:0]  high_nibble;
      logic        echo_on;
   } parse_state_type;

   typedef struct packed {
      logic        echo_valid;
      logic [7:0]  echo_byte;
      logic        write_valid;
      logic [31:0] write_address;
      logic [7:0]  write_byte;
      logic        dump_valid;
      logic [31:0] dump_address;
      logic [31:0] dump_length;
      logic        go_valid;
      logic [31:0] go_address;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] nibble;
   } hex_digit_type;

   // Lowercase hex only; anything else is flagged invalid.
   function automatic hex_digit_type hex_digit(input logic [7:0] c);
      hex_digit_type d;
      d.valid  = 1'b0;
      d.nibble = 4'h0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d.valid  = 1'b1;
         d.nibble = c[3:0];
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         d.valid  = 1'b1;
         d.nibble = c[3:0] + 4'd9;
      end
      return d;
   endfunction

endpackage

### sv/shlp_step.sv
// Next-state and result logic for one received byte.
`timescale 1ns / 1ps

module shlp_step
   import shlp_pkg::*;
(
   input  parse_state_type cur,
   input  logic [7:0]      rx_byte,
   output parse_state_type nxt,
   output result_type      res
);

   hex_digit_type dig;

   assign dig = hex_digit(rx_byte);

   always_comb begin
      nxt = cur;
      res = '0;
      if (cur.phase != ST_HALT) begin
         if (cur.echo_on) begin
            res.echo_valid = 1'b1;
            res.echo_byte  = rx_byte;
         end else if (rx_byte == CH_NL) begin
            res.echo_valid = 1'b1;
            res.echo_byte  = CH_DOT;
         end
         case (cur.phase)
            ST_IDLE: begin
               if (rx_byte == CH_SPACE) begin
                  nxt.phase = cur.phase;
               end else if (rx_byte == CH_ZERO) begin
                  nxt.phase  = ST_X;
                  nxt.target = TGT_LOAD;
               end else if (rx_byte == CH_UP_E) begin
                  nxt.echo_on = ~cur.echo_on;
                  nxt.phase   = ST_SKIP;
               end else if (rx_byte == CH_UP_D) begin
                  nxt.target = TGT_DUMP;
                  nxt.phase  = ST_ZERO;
               end else if (rx_byte == CH_UP_G) begin
                  nxt.target = TGT_GO;
                  nxt.phase  = ST_ZERO;
               end else if (rx_byte != CH_NL) begin
                  nxt.phase = ST_SKIP;
               end
            end
            ST_ZERO: begin
               if (rx_byte == CH_ZERO) nxt.phase = ST_X;
               else if (rx_byte == CH_NL) nxt.phase = ST_IDLE;
            end
            ST_X: begin
               if (rx_byte == CH_LO_X) begin
                  nxt.phase       = ST_ADDR;
                  nxt.address_acc = '0;
               end else if (rx_byte == CH_NL) begin
                  nxt.phase = ST_IDLE;
               end else begin
                  nxt.phase = ST_SKIP;
               end
            end
            ST_ADDR: begin
               if (rx_byte == CH_SPACE || rx_byte == CH_NL) begin
                  nxt.count_acc = '0;
                  if (cur.target == TGT_DUMP) begin
                     nxt.phase = ST_LEN;
                  end else if (cur.target == TGT_GO) begin
                     nxt.phase      = ST_HALT;
                     res.go_valid   = 1'b1;
                     res.go_address = cur.address_acc;
                  end else begin
                     nxt.phase = ST_DHI;
                  end
               end else begin
                  nxt.address_acc = dig.valid ? {cur.address_acc[27:0], dig.nibble} : '1;
               end
            end
            ST_DHI: begin
               if (rx_byte == CH_NL) begin
                  nxt.phase = ST_IDLE;
               end else if (rx_byte == CH_SPACE) begin
                  nxt.phase = cur.phase;
               end else if (cur.count_acc == 32'(BYTES_PER_LINE)) begin
                  nxt.phase = ST_SKIP;
               end else begin
                  nxt.phase       = ST_DLO;
                  nxt.high_nibble = dig.valid ? dig.nibble : 4'hF;
               end
            end
            ST_DLO: begin
               if (rx_byte == CH_NL) begin
                  nxt.phase = ST_IDLE;
               end else begin
                  nxt.phase         = ST_DHI;
                  res.write_valid   = 1'b1;
                  res.write_address = cur.address_acc + cur.count_acc;
                  res.write_byte    = dig.valid ? {cur.high_nibble, dig.nibble} : 8'hFF;
                  nxt.count_acc     = cur.count_acc + 32'd1;
               end
            end
            ST_LEN: begin
               if (rx_byte == CH_NL) begin
                  res.dump_valid   = 1'b1;
                  res.dump_address = cur.address_acc;
                  res.dump_length  = cur.count_acc;
                  nxt.phase        = ST_IDLE;
               end else begin
                  nxt.count_acc = dig.valid ? {cur.count_acc[27:0], dig.nibble} : '1;
               end
            end
            ST_SKIP: begin
               if (rx_byte == CH_NL) nxt.phase = ST_IDLE;
            end
            default: begin
               nxt.phase = ST_HALT;
            end
         endcase
      end
   end

endmodule

### sv/serial_hex_loader_parser.sv
// Top level of the serial hex loader command parser.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_rx_byte
//   rsp      out        rsp_valid / rsp_ready  echo, write, dump and go fields
//
// One request is parsed in the cycle it is accepted; its result appears in the
// output register on the next cycle. A new request is taken every cycle while
// the output register is empty or being drained, so throughput is one byte per
// cycle, set by the single parse step between parser state and output register.
// Synchronous active-high reset returns the parser to idle with echo off and
// empties the output register. While rsp_ready is low a held result blocks
// req_ready; nothing is dropped. After a go request every byte yields all zeros.
`timescale 1ns / 1ps
`include "serial_hex_loader_parser_assert.svh"

module serial_hex_loader_parser
   import shlp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_echo_valid,
   output logic [7:0]  rsp_echo_byte,
   output logic        rsp_write_valid,
   output logic [31:0] rsp_write_address,
   output logic [7:0]  rsp_write_byte,
   output logic        rsp_dump_valid,
   output logic [31:0] rsp_dump_address,
   output logic [31:0] rsp_dump_length,
   output logic        rsp_go_valid,
   output logic [31:0] rsp_go_address
);

   parse_state_type state_ff;
   parse_state_type state_in;
   result_type      result_ff;
   result_type      result_in;
   logic            rsp_valid_ff;
   logic            accept;

   // Output register frees up in the same cycle it is drained.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   shlp_step u_step (
      .cur     (state_ff),
      .rx_byte (req_rx_byte),
      .nxt     (state_in),
      .res     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff         <= 1'b0;
         state_ff.phase       <= ST_IDLE;
         state_ff.target      <= TGT_LOAD;
         state_ff.address_acc <= '0;
         state_ff.count_acc   <= '0;
         state_ff.high_nibble <= '0;
         state_ff.echo_on     <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
         state_ff     <= state_in;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload, no reset needed.
   always_ff @(posedge clock) begin
      if (accept) result_ff <= result_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_echo_valid    = result_ff.echo_valid;
   assign rsp_echo_byte     = result_ff.echo_byte;
   assign rsp_write_valid   = result_ff.write_valid;
   assign rsp_write_address = result_ff.write_address;
   assign rsp_write_byte    = result_ff.write_byte;
   assign rsp_dump_valid    = result_ff.dump_valid;
   assign rsp_dump_address  = result_ff.dump_address;
   assign rsp_dump_length   = result_ff.dump_length;
   assign rsp_go_valid      = result_ff.go_valid;
   assign rsp_go_address    = result_ff.go_address;

   // At most one memory-side request per result.
   `SHLP_ASSERT_IMPL(a_one_request, clock, reset, rsp_valid_ff,
      $countones({result_ff.write_valid, result_ff.dump_valid, result_ff.go_valid}) <= 1,
      "more than one request in a result")

   // A go request always halts the parser.
   `SHLP_ASSERT_NEXT(a_go_halts, clock, reset, accept && result_in.go_valid,
      state_ff.phase == ST_HALT, "go request did not halt")

   // Once halted, results are all zero.
   `SHLP_ASSERT_NEXT(a_halt_quiet, clock, reset, accept && state_ff.phase == ST_HALT,
      result_ff == '0, "nonzero result while halted")

   // Data byte count never passes the per-line limit.
   `SHLP_ASSERT_IMPL(a_line_limit, clock, reset,
      state_ff.phase == ST_DHI || state_ff.phase == ST_DLO,
      state_ff.count_acc <= 32'(BYTES_PER_LINE), "data byte count over line limit")

endmodule

### sim/serial_hex_loader_parser_tb.sv
// Self-checking testbench for the serial hex loader command parser.
`timescale 1ns / 1ps

module serial_hex_loader_parser_tb
   import shlp_pkg::*;
();

   // Run bounds.
   localparam int unsigned REQUEST_TARGET = 1400;
   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned DRAIN_CYCLES   = 10;
   localparam int unsigned PRINT_CAP      = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_echo_valid;
   logic [7:0]  rsp_echo_byte;
   logic        rsp_write_valid;
   logic [31:0] rsp_write_address;
   logic [7:0]  rsp_write_byte;
   logic        rsp_dump_valid;
   logic [31:0] rsp_dump_address;
   logic [31:0] rsp_dump_length;
   logic        rsp_go_valid;
   logic [31:0] rsp_go_address;

   serial_hex_loader_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_echo_valid    (rsp_echo_valid),
      .rsp_echo_byte     (rsp_echo_byte),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_byte    (rsp_write_byte),
      .rsp_dump_valid    (rsp_dump_valid),
      .rsp_dump_address  (rsp_dump_address),
      .rsp_dump_length   (rsp_dump_length),
      .rsp_go_valid      (rsp_go_valid),
      .rsp_go_address    (rsp_go_address)
   );

   always #5 clock = ~clock;

   // Monitor state as the parser should hold it after each accepted request.
   phase_type   mon_phase  = ST_IDLE;
   target_type  mon_target = TGT_LOAD;
   logic [31:0] mon_addr   = '0;
   logic [31:0] mon_count  = '0;
   logic [7:0]  mon_hi     = '0;
   logic        mon_echo   = 1'b0;

   // Outputs owed by the parser, oldest first; one per accepted request.
   result_type  responses_due[$];

   int unsigned requests_sent = 0;
   int unsigned responses_seen = 0;
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   bit          calm = 1'b0;   // no idling on either side while set

   // Lowercase hex only; anything else reads as all ones.
   function automatic logic [31:0] hex_value(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return 32'(c - CH_ZERO);
      if (c >= CH_LO_A && c <= CH_LO_F) return 32'(c - CH_LO_A) + 32'd10;
      return '1;
   endfunction

   // Advances the monitor state by one console byte and returns the output
   // the parser owes for it.
   function automatic result_type parse_console_byte(input logic [7:0] c);
      result_type  r;
      logic [31:0] v;
      r = '0;
      if (mon_phase == ST_HALT) return r;
      v = hex_value(c);

      // Echo uses the setting in force before this byte is parsed.
      if (mon_echo) begin
         r.echo_valid = 1'b1;
         r.echo_byte  = c;
      end else if (c == CH_NL) begin
         r.echo_valid = 1'b1;
         r.echo_byte  = CH_DOT;
      end

      case (mon_phase)
         ST_IDLE: begin
            if (c == CH_SPACE) begin
            end else if (c == CH_ZERO) begin
               mon_phase  = ST_X;
               mon_target = TGT_LOAD;
            end else if (c == CH_UP_E) begin
               mon_echo  = ~mon_echo;
               mon_phase = ST_SKIP;
            end else if (c == CH_UP_D) begin
               mon_target = TGT_DUMP;
               mon_phase  = ST_ZERO;
            end else if (c == CH_UP_G) begin
               mon_target = TGT_GO;
               mon_phase  = ST_ZERO;
            end else if (c != CH_NL) begin
               mon_phase = ST_SKIP;
            end
         end
         ST_ZERO: begin
            if (c == CH_ZERO) mon_phase = ST_X;
            else if (c == CH_NL) mon_phase = ST_IDLE;
         end
         ST_X: begin
            if (c == CH_LO_X) begin
               mon_phase = ST_ADDR;
               mon_addr  = '0;
            end else if (c == CH_NL) begin
               mon_phase = ST_IDLE;
            end else begin
               mon_phase = ST_SKIP;
            end
         end
         ST_ADDR: begin
            if (c == CH_SPACE || c == CH_NL) begin
               mon_count = '0;
               if (mon_target == TGT_DUMP) begin
                  mon_phase = ST_LEN;
               end else if (mon_target == TGT_GO) begin
                  mon_phase    = ST_HALT;
                  r.go_valid   = 1'b1;
                  r.go_address = mon_addr;
               end else begin
                  mon_phase = ST_DHI;
               end
            end else begin
               mon_addr = (mon_addr << 4) | v;
            end
         end
         ST_DHI: begin
            if (c == CH_NL) begin
               mon_phase = ST_IDLE;
            end else if (c == CH_SPACE) begin
            end else if (mon_count == 32'(BYTES_PER_LINE)) begin
               mon_phase = ST_SKIP;   // line too long
            end else begin
               mon_phase = ST_DLO;
               mon_hi    = {v[3:0], 4'h0};   // bad digit gives 0xF0
            end
         end
         ST_DLO: begin
            if (c == CH_NL) begin
               mon_phase = ST_IDLE;
            end else begin
               mon_phase       = ST_DHI;
               r.write_valid   = 1'b1;
               r.write_address = mon_addr + mon_count;
               r.write_byte    = mon_hi | v[7:0];
               mon_count       = mon_count + 32'd1;
            end
         end
         ST_LEN: begin
            if (c == CH_NL) begin
               r.dump_valid   = 1'b1;
               r.dump_address = mon_addr;
               r.dump_length  = mon_count;
               mon_phase      = ST_IDLE;
            end else begin
               mon_count = (mon_count << 4) | v;
            end
         end
         ST_SKIP: begin
            if (c == CH_NL) mon_phase = ST_IDLE;
         end
         default: mon_phase = ST_HALT;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Offers one console byte, holding it until accepted; random gaps before.
   task automatic send_byte(input logic [7:0] b);
      while (!calm && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      responses_due.push_back(parse_console_byte(b));
      requests_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // Stops offering requests and waits until every owed output has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (responses_due.size() != 0) @(posedge clock);
   endtask

   // Any byte except 'G', so random traffic can never halt the parser.
   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      b = 8'($urandom_range(255));
      if (b == CH_UP_G) b = CH_SPACE;
      return b;
   endfunction

   function automatic logic [7:0] pick_hex(input int unsigned bad_pct);
      string digits;
      digits = "0123456789abcdef";
      if ($urandom_range(99) < bad_pct) return noise_byte();
      return digits[$urandom_range(15)];
   endfunction

   task automatic send_hex_run(input int unsigned n, input int unsigned bad_pct);
      repeat (n) send_byte(pick_hex(bad_pct));
   endtask

   // "0x<addr> <pairs>\n", sometimes overlong, odd, or split across lines.
   task automatic send_load_line();
      int unsigned pairs;
      bit          odd_tail;
      send_byte(CH_ZERO);
      send_byte(CH_LO_X);
      send_hex_run(($urandom_range(99) < 5) ? $urandom_range(9, 10) : $urandom_range(1, 8), 2);
      send_byte(($urandom_range(99) < 85) ? CH_SPACE : CH_NL);
      pairs    = ($urandom_range(99) < 10) ? $urandom_range(17, 19) : $urandom_range(0, 16);
      odd_tail = ($urandom_range(99) < 5);
      for (int unsigned i = 0; i < pairs; i++) begin
         if ($urandom_range(99) < 25) send_byte(CH_SPACE);
         send_byte(pick_hex(3));
         if (!(odd_tail && i == pairs - 1)) send_byte(pick_hex(3));
      end
      send_byte(CH_NL);
   endtask

   // "D 0x<addr> <len>\n", address sometimes ended by the newline.
   task automatic send_dump_line();
      send_byte(CH_UP_D);
      if ($urandom_range(99) < 50) send_byte(CH_SPACE);
      send_byte(CH_ZERO);
      send_byte(CH_LO_X);
      send_hex_run($urandom_range(1, 8), 2);
      send_byte(($urandom_range(99) < 80) ? CH_SPACE : CH_NL);
      send_hex_run($urandom_range(0, 8), 3);
      send_byte(CH_NL);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Echo toggling, extreme byte values and an unknown command.
   task automatic test_echo_and_unknown();
      send_text("E\n");         // 'E' itself goes out under echo off
      send_byte(8'h00);         // unknown command, skip to newline
      send_byte(8'hFF);
      send_byte(CH_NL);
      send_text("E\n");         // toggled back off; this 'E' is echoed
   endtask

   // Bad address digit saturates the address, a space as low digit is a bad
   // digit, and the second byte wraps the address to zero.
   task automatic test_load_wrap();
      send_text("0xz a 9f\n");
   endtask

   // Address ended by newline continues with the length; bad length digit.
   task automatic test_dump_split();
      send_text("D0x1\ng\n");
   endtask

   task automatic test_random_lines();
      bit paused;
      int unsigned pick;
      paused = 1'b0;
      while (requests_sent < REQUEST_TARGET) begin
         // Long stretch with both sides running flat out.
         calm = (requests_sent >= 600 && requests_sent < 900);
         // Once, let the pipeline empty completely before sending more.
         if (!paused && requests_sent >= 400) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 45) begin
            send_load_line();
         end else if (pick < 70) begin
            send_dump_line();
         end else if (pick < 78) begin
            send_byte(CH_UP_E);
            if ($urandom_range(99) < 50) repeat ($urandom_range(1, 3)) send_byte(noise_byte());
            send_byte(CH_NL);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 8)) send_byte(noise_byte());
            send_byte(CH_NL);
         end else begin
            // Broken command prefix followed by junk.
            send_byte(($urandom_range(1) != 0) ? CH_ZERO : CH_UP_D);
            repeat ($urandom_range(1, 4)) send_byte(noise_byte());
            send_byte(CH_NL);
         end
      end
      calm = 1'b0;
   endtask

   // Go must come last: the parser halts and every later byte gives zeros.
   task automatic test_go_and_halt();
      send_text("\nG 0x8000abcd\n0x1 ab\n");
      send_byte(8'hFF);
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------

   always @(posedge clock) rsp_ready <= calm || ($urandom_range(99) >= 10);

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("mismatch at response %0d: %s got %h want %h",
                  responses_seen, what, got, want);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   always @(posedge clock) begin : check_outputs
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (responses_due.size() == 0) begin
            report_mismatch("response with none owed", 32'd0, 32'd0);
         end else begin
            want = responses_due.pop_front();
            check_field("echo_valid", 32'(rsp_echo_valid), 32'(want.echo_valid));
            check_field("echo_byte", 32'(rsp_echo_byte), 32'(want.echo_byte));
            check_field("write_valid", 32'(rsp_write_valid), 32'(want.write_valid));
            check_field("write_address", rsp_write_address, want.write_address);
            check_field("write_byte", 32'(rsp_write_byte), 32'(want.write_byte));
            check_field("dump_valid", 32'(rsp_dump_valid), 32'(want.dump_valid));
            check_field("dump_address", rsp_dump_address, want.dump_address);
            check_field("dump_length", rsp_dump_length, want.dump_length);
            check_field("go_valid", 32'(rsp_go_valid), 32'(want.go_valid));
            check_field("go_address", rsp_go_address, want.go_address);
         end
         responses_seen++;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_echo_and_unknown();
      test_load_wrap();
      test_dump_split();
      test_random_lines();
      test_go_and_halt();

      wait_drained();
      // Catch any stray response after the last owed one.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
